// ===== rtl/ipv4rt_pkg.sv =====
// Types, constants and helpers shared by the IPv4 range table lookup block.
`default_nettype none

package ipv4rt_pkg;

  localparam int unsigned POS_W               = 17;
  localparam int unsigned DEFAULT_MAX_ENTRIES = 65536;
  localparam logic [7:0]  OCTET_LAST          = 8'hFF;
  localparam int unsigned TOP_SHIFT           = 24;

  typedef enum logic [1:0] {
    OP_WR_INDEX = 2'd0,
    OP_WR_ENTRY = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_NOP      = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  bucket;
    logic [16:0] start_position;
    logic [15:0] entry_address;
    logic [31:0] address_value;
    logic [31:0] offset_in;
    logic [7:0]  length_in;
  } cmd_t;

  typedef struct packed {
    logic [15:0] entry_index;
    logic [31:0] text_offset;
    logic [7:0]  text_length;
    logic        not_found;
  } rsp_t;

  // Midpoint of two positions without losing the carry.
  function automatic logic [POS_W-1:0] mid_of(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W:1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv4_range_table_lookup_top.sv =====
// IPv4 range table lookup: first-octet index, range table and binary search sequencer.
//
// Opcodes 0 and 1 write an index slot or a table entry at the edge that accepts
// the item. A lookup reads the index slots for its top octet and the next octet
// when accepted, then probes the range-end memory once per cycle: each probe's
// read data is compared and the next midpoint is picked from precomputed
// candidates in the same cycle, so one binary-search step costs one memory read.
// A lookup ends in S_FIN, or in S_FETCH when the entry at the lower bound needs a
// separate fetch. The search makes at most k = ceil(log2(span+1)) probes, at most
// 17 for a 65536-entry span. The result strobe done_o comes in the cycle
// busy_o drops, so a new item can be accepted while the result is shown. The
// receiver cannot stall: done_o and rsp_o are valid for exactly one cycle.
`default_nettype none

module ipv4_range_table_lookup_top
  import ipv4rt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  cmd_t        cmd_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i
);

  localparam int unsigned AW     = $clog2(MAX_ENTRIES);
  localparam int unsigned EXT_W  = AW + POS_W;
  localparam int unsigned WEXT_W = AW + 16;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SPAN  = 5'b00010,
    S_CMP   = 5'b00100,
    S_FIN   = 5'b01000,
    S_FETCH = 5'b10000
  } state_e;

  function automatic logic [AW-1:0] pos_idx(input logic [POS_W-1:0] pos);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(pos);
    return ext[AW-1:0];
  endfunction

  function automatic logic pos_ok(input logic [POS_W-1:0] pos);
    logic [EXT_W-1:0] ext;
    ext = EXT_W'(pos);
    return ext < EXT_W'(MAX_ENTRIES);
  endfunction

  // storage
  logic [POS_W-1:0] idx_mem  [256];
  logic [31:0]      end_mem  [MAX_ENTRIES];
  logic [39:0]      data_mem [MAX_ENTRIES];

  logic [POS_W-1:0] idx_lo_rd_q, idx_hi_rd_q;
  logic [31:0]      end_rd_q;
  logic [39:0]      data_rd_q;

  state_e           state_q, state_d;
  logic [16:0]      cnt_q;
  logic [31:0]      addr_q;
  logic [POS_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic             mid_ok_q, mid_ok_d;
  logic             done_q, done_d;
  rsp_t             rsp_q, rsp_d;

  logic             accept;
  logic [7:0]       cmd_top;
  logic [WEXT_W-1:0] wr_ext;
  logic             wr_ok;

  logic             end_re, data_re;
  logic [AW-1:0]    end_ridx, data_ridx;

  logic [7:0]       cur_top;
  logic [POS_W-1:0] span_hi;
  logic [31:0]      end_val;
  logic             go_up;
  logic [POS_W-1:0] mid_p1;
  logic [POS_W-1:0] nlo, nhi, nmid;
  logic             ncont;
  logic             hi_hit, lo_found;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign rsp_o   = rsp_q;
  assign cmd_top = 8'(cmd_i.address_value >> TOP_SHIFT);
  assign wr_ext  = WEXT_W'(cmd_i.entry_address);
  assign wr_ok   = wr_ext < WEXT_W'(MAX_ENTRIES);

  // index memory: one write port, two read ports (top and top+1)
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.opcode == OP_WR_INDEX) begin
      idx_mem[cmd_i.bucket] <= cmd_i.start_position;
    end
    if (accept && cmd_i.opcode == OP_LOOKUP) begin
      idx_lo_rd_q <= idx_mem[cmd_top];
      idx_hi_rd_q <= idx_mem[cmd_top + 8'd1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.opcode == OP_WR_ENTRY && wr_ok) begin
      end_mem[wr_ext[AW-1:0]] <= cmd_i.address_value;
    end
    if (end_re) begin
      end_rd_q <= end_mem[end_ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.opcode == OP_WR_ENTRY && wr_ok) begin
      data_mem[wr_ext[AW-1:0]] <= {cmd_i.offset_in, cmd_i.length_in};
    end
    if (data_re) begin
      data_rd_q <= data_mem[data_ridx];
    end
  end

  // search datapath
  always_comb begin
    cur_top = 8'(addr_q >> TOP_SHIFT);
    span_hi = (cur_top == OCTET_LAST || idx_hi_rd_q == '0) ? cnt_q : idx_hi_rd_q;
    // a probe beyond the store reads as zero
    end_val = mid_ok_q ? end_rd_q : 32'd0;
    go_up   = addr_q > end_val;
    mid_p1  = mid_q + POS_W'(1);

    if (state_q == S_SPAN) begin
      nlo   = idx_lo_rd_q;
      nhi   = span_hi;
      nmid  = mid_of(idx_lo_rd_q, span_hi);
      ncont = idx_lo_rd_q < span_hi;
    end else if (go_up) begin
      nlo   = mid_p1;
      nhi   = hi_q;
      nmid  = mid_of(mid_p1, hi_q);
      ncont = mid_p1 < hi_q;
    end else begin
      nlo   = lo_q;
      nhi   = mid_q;
      nmid  = mid_of(lo_q, mid_q);
      ncont = lo_q < mid_q;
    end

    hi_hit   = (hi_q < cnt_q) && (end_val >= addr_q);
    lo_found = (lo_q < cnt_q) && pos_ok(lo_q);
  end

  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    mid_ok_d  = mid_ok_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    end_re    = 1'b0;
    end_ridx  = pos_idx(nmid);
    data_re   = 1'b0;
    data_ridx = pos_idx(nhi);

    unique case (state_q)
      S_IDLE: begin
        if (accept && cmd_i.opcode == OP_LOOKUP) begin
          state_d = S_SPAN;
        end
      end
      S_SPAN, S_CMP: begin
        lo_d = nlo;
        hi_d = nhi;
        if (ncont) begin
          mid_d    = nmid;
          mid_ok_d = pos_ok(nmid);
          end_re   = pos_ok(nmid);
          state_d  = S_CMP;
        end else begin
          // final check at the upper bound; mid_ok tracks hi from here on
          mid_ok_d = pos_ok(nhi);
          end_re   = pos_ok(nhi);
          end_ridx = pos_idx(nhi);
          data_re  = pos_ok(nhi);
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (hi_hit) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (mid_ok_q) begin
            rsp_d = '{entry_index: hi_q[15:0], text_offset: data_rd_q[39:8],
                      text_length: data_rd_q[7:0], not_found: 1'b0};
          end else begin
            rsp_d = '{entry_index: 16'd0, text_offset: 32'd0,
                      text_length: 8'd0, not_found: 1'b1};
          end
        end else if (!lo_found) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          rsp_d   = '{entry_index: 16'd0, text_offset: 32'd0,
                      text_length: 8'd0, not_found: 1'b1};
        end else if (lo_q == hi_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          rsp_d   = '{entry_index: lo_q[15:0], text_offset: data_rd_q[39:8],
                      text_length: data_rd_q[7:0], not_found: 1'b0};
        end else begin
          data_re   = 1'b1;
          data_ridx = pos_idx(lo_q);
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        rsp_d   = '{entry_index: lo_q[15:0], text_offset: data_rd_q[39:8],
                    text_length: data_rd_q[7:0], not_found: 1'b0};
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.opcode == OP_LOOKUP) begin
      addr_q <= cmd_i.address_value;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    mid_ok_q <= mid_ok_d;
    rsp_q    <= rsp_d;
  end

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_FIN || $past(state_q) == S_FETCH))
    else $error("result emitted outside the final search states");

  a_probe_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (lo_q <= mid_q && mid_q < hi_q))
    else $error("probe position outside the search interval");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.not_found) |-> (rsp_o.entry_index == 16'd0 &&
      rsp_o.text_offset == 32'd0 && rsp_o.text_length == 8'd0))
    else $error("miss result carries nonzero fields");

endmodule

`default_nettype wire
